// ===== hdl/crd_pkg.sv =====
// Package: shared constants and types for the CSV record deframer.
package crd_pkg;

    localparam logic [7:0] QUOTE_BYTE     = 8'h22;
    localparam logic [7:0] LF_BYTE        = 8'h0A;
    localparam logic [7:0] CR_BYTE        = 8'h0D;
    localparam logic [7:0] SPACE_BYTE     = 8'h20;
    localparam logic [7:0] DELIMITER_INIT = 8'h2C;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } crd_item_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] out_byte;
        logic       record_end;
    } crd_result_t;

endpackage

// ===== hdl/crd_in_if.sv =====
// Interface: input byte channel with valid/ready handshake.
interface crd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

// ===== hdl/crd_out_if.sv =====
// Interface: output record text channel with valid/ready handshake.
interface crd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       record_end;

    modport source (output valid, output out_byte, output record_end, input ready);
    modport sink   (input valid, input out_byte, input record_end, output ready);
endinterface

// ===== hdl/csv_record_deframer.sv =====
// Top level: CSV record deframer with input register, decoder and result register.
//
//   channel  dir  handshake      payload
//   rx       in   valid/ready    data_byte[7:0], end_of_input
//   tx       out  valid/ready    out_byte[7:0], record_end
//   cfg      in   cfg_wr_en      cfg_wr_data[7:0] -> field delimiter
//
// One byte per cycle sustained while tx is ready. The input register and result
// register form a two-stage pipeline that each byte passes through, and the parser
// flags update as a byte leaves the input register.
// Reset clears the flags and both valid bits and sets the delimiter to a comma.
// A stall on tx holds the result; rx keeps taking bytes until both stages are full.
module csv_record_deframer
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    crd_in_if.sink     rx,
    crd_out_if.source  tx
);
    import crd_pkg::*;

    logic        in_valid_reg;
    crd_item_t   in_item_reg;
    logic [7:0]  delimiter_reg;
    logic        advance;
    logic        can_load;
    crd_result_t result;

    assign advance  = in_valid_reg && can_load;
    assign rx.ready = !in_valid_reg || can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            delimiter_reg <= DELIMITER_INIT;
        end
        else
        begin
            if (rx.ready)
            begin
                in_valid_reg <= rx.valid;
            end
            if (cfg_wr_en)
            begin
                delimiter_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_item_reg.data_byte    <= rx.data_byte;
            in_item_reg.end_of_input <= rx.end_of_input;
        end
    end

    crd_byte_decode u_decode
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .item            (in_item_reg),
        .field_delimiter (delimiter_reg),
        .result          (result)
    );

    crd_out_stage u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .result   (result),
        .can_load (can_load),
        .tx       (tx)
    );

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("input item dropped while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> rx.ready)
        else $error("not ready with empty input register");

    a_flow_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.valid |=> tx.valid)
        else $error("result not presented");

endmodule

// ===== hdl/crd_byte_decode.sv =====
// Byte decoder: quote, delimiter and record-end rules with the parser flags.
module crd_byte_decode
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  crd_pkg::crd_item_t  item,
    input  logic [7:0]          field_delimiter,
    output crd_pkg::crd_result_t result
);
    import crd_pkg::*;

    logic inside_quotes_reg;
    logic inside_quotes_next;
    logic quote_pending_reg;
    logic quote_pending_next;
    logic record_has_content_reg;
    logic record_has_content_next;

    always_comb
    begin
        logic       outside;
        logic [7:0] b;
        b                       = item.data_byte;
        outside                 = 1'b0;
        inside_quotes_next      = inside_quotes_reg;
        quote_pending_next      = quote_pending_reg;
        record_has_content_next = record_has_content_reg;
        result.valid            = 1'b0;
        result.out_byte         = 8'h00;
        result.record_end       = 1'b0;

        if (item.end_of_input)
        begin
            result.valid            = record_has_content_reg;
            result.record_end       = record_has_content_reg;
            inside_quotes_next      = 1'b0;
            quote_pending_next      = 1'b0;
            record_has_content_next = 1'b0;
        end
        else if (quote_pending_reg)
        begin
            quote_pending_next = 1'b0;
            if (b == QUOTE_BYTE)
            begin
                result.valid            = 1'b1;
                result.out_byte         = QUOTE_BYTE;
                record_has_content_next = 1'b1;
            end
            else
            begin
                inside_quotes_next = 1'b0;
                outside            = 1'b1;
            end
        end
        else if (inside_quotes_reg)
        begin
            if (b == QUOTE_BYTE)
            begin
                quote_pending_next = 1'b1;
            end
            else
            begin
                result.valid            = 1'b1;
                result.out_byte         = b;
                record_has_content_next = 1'b1;
            end
        end
        else
        begin
            outside = 1'b1;
        end

        if (outside)
        begin
            if (b == QUOTE_BYTE)
            begin
                inside_quotes_next = 1'b1;
            end
            else if (b == field_delimiter)
            begin
                result.valid    = record_has_content_reg;
                result.out_byte = SPACE_BYTE;
            end
            else if (b inside {LF_BYTE, CR_BYTE})
            begin
                result.valid            = record_has_content_reg;
                result.record_end       = record_has_content_reg;
                record_has_content_next = 1'b0;
            end
            else
            begin
                result.valid            = 1'b1;
                result.out_byte         = b;
                record_has_content_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_quotes_reg      <= 1'b0;
            quote_pending_reg      <= 1'b0;
            record_has_content_reg <= 1'b0;
        end
        else if (advance)
        begin
            inside_quotes_reg      <= inside_quotes_next;
            quote_pending_reg      <= quote_pending_next;
            record_has_content_reg <= record_has_content_next;
        end
    end

    a_pending_in_quotes: assert property (@(posedge clk) disable iff (!rst_n)
        quote_pending_reg |-> inside_quotes_reg)
        else $error("quote pending outside quotes");

    a_eoi_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.end_of_input |=>
            !inside_quotes_reg && !quote_pending_reg && !record_has_content_reg)
        else $error("flags not cleared after end of input");

    a_end_needs_content: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.record_end |-> record_has_content_reg)
        else $error("record end without content");

    a_byte_sets_content: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.valid && !result.record_end && !item.end_of_input |=>
            record_has_content_reg)
        else $error("content flag not set after emitted byte");

endmodule

// ===== hdl/crd_out_stage.sv =====
// Result register: holds one transfer for the output channel.
module crd_out_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  crd_pkg::crd_result_t result,
    output logic                 can_load,
    crd_out_if.source            tx
);
    import crd_pkg::*;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       record_end_reg;

    assign can_load = !out_valid_reg || tx.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= result.valid;
        end
        else if (tx.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.valid)
        begin
            out_byte_reg   <= result.out_byte;
            record_end_reg <= result.record_end;
        end
    end

    assign tx.valid      = out_valid_reg;
    assign tx.out_byte   = out_byte_reg;
    assign tx.record_end = record_end_reg;

    a_end_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && record_end_reg |-> out_byte_reg == SPACE_BYTE - SPACE_BYTE)
        else $error("record end carries a byte");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !tx.ready |=> out_valid_reg && $stable(out_byte_reg))
        else $error("pending result lost");

    a_advance_room: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> can_load)
        else $error("advance into a full result register");

endmodule

// ===== tb/tb_csv_record_deframer.sv =====
// Testbench: random and directed CSV byte streams with a self-checking scoreboard.
module tb_csv_record_deframer;
    import crd_pkg::*;

    localparam int LIMIT_CYCLES = 800000;
    localparam int PHASE_ITEMS  = 160;
    localparam int DRAIN_CYCLES = 6;

    typedef struct {
        logic [7:0] text;
        logic       last;
    } joined_char_t;

    class csv_join_scoreboard;
        logic [7:0]   delimiter;
        bit           in_quotes;
        bit           quote_seen;
        bit           has_text;
        joined_char_t joined_q[$];

        function new();
            delimiter  = DELIMITER_INIT;
            in_quotes  = 1'b0;
            quote_seen = 1'b0;
            has_text   = 1'b0;
        endfunction

        function void emit_char(logic [7:0] c);
            joined_char_t e;
            e.text = c;
            e.last = 1'b0;
            joined_q.insert(joined_q.size(), e);
            has_text = 1'b1;
        endfunction

        function void emit_end();
            joined_char_t e;
            e.text = 8'h00;
            e.last = 1'b1;
            joined_q.insert(joined_q.size(), e);
            has_text = 1'b0;
        endfunction

        function void plain_byte(logic [7:0] b);
            if (b == QUOTE_BYTE)
                in_quotes = 1'b1;
            else if (b == delimiter)
            begin
                if (has_text)
                    emit_char(SPACE_BYTE);
            end
            else if (b == LF_BYTE || b == CR_BYTE)
            begin
                if (has_text)
                    emit_end();
            end
            else
                emit_char(b);
        endfunction

        // note one accepted input transfer
        function void take_byte(crd_item_t item);
            if (item.end_of_input)
            begin
                if (has_text)
                    emit_end();
                in_quotes  = 1'b0;
                quote_seen = 1'b0;
                has_text   = 1'b0;
            end
            else if (quote_seen)
            begin
                quote_seen = 1'b0;
                if (item.data_byte == QUOTE_BYTE)
                    emit_char(QUOTE_BYTE);
                else
                begin
                    in_quotes = 1'b0;
                    plain_byte(item.data_byte);
                end
            end
            else if (in_quotes)
            begin
                if (item.data_byte == QUOTE_BYTE)
                    quote_seen = 1'b1;
                else
                    emit_char(item.data_byte);
            end
            else
                plain_byte(item.data_byte);
        endfunction

        function int pending();
            return joined_q.size();
        endfunction

        // check one output transfer against the oldest expectation
        function bit check_out(logic [7:0] c, logic last, output string why);
            joined_char_t want;
            why = "";
            if (joined_q.size() == 0)
            begin
                why = $sformatf("unexpected output: out_byte %02h record_end %0b", c, last);
                return 1'b0;
            end
            want = joined_q.pop_front();
            if (last !== want.last)
            begin
                why = $sformatf("record_end %0b, want %0b (out_byte %02h, want %02h)",
                                last, want.last, c, want.text);
                return 1'b0;
            end
            if (!last && c !== want.text)
            begin
                why = $sformatf("out_byte %02h, want %02h", c, want.text);
                return 1'b0;
            end
            return 1'b1;
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    crd_in_if  rx_if ();
    crd_out_if tx_if ();

    csv_record_deframer dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rx          (rx_if),
        .tx          (tx_if)
    );

    csv_join_scoreboard sb = new();
    int  error_count;
    int  cycle_count;
    int  sent_count;
    bit  calm;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string why);
        $display("mismatch at cycle %0d: %s", cycle_count, why);
        error_count++;
    endtask

    function automatic int gap_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count % 256 == 0)
            calm = ($urandom_range(0, 3) == 0);
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rx_if.valid && rx_if.ready)
            sb.take_byte('{data_byte: rx_if.data_byte, end_of_input: rx_if.end_of_input});
    end

    always @(posedge clk)
    begin : out_monitor
        string why;
        if (rst_n && tx_if.valid && tx_if.ready)
        begin
            if (!sb.check_out(tx_if.out_byte, tx_if.record_end, why))
                report_mismatch(why);
        end
    end

    initial
    begin : sink_side
        int stall;
        stall = 0;
        tx_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                tx_if.ready = 1'b0;
                stall--;
            end
            else
            begin
                tx_if.ready = 1'b1;
                stall = gap_len();
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic eoi);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            @(negedge clk);
            rx_if.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        rx_if.valid        = 1'b1;
        rx_if.data_byte    = b;
        rx_if.end_of_input = eoi;
        do
            @(posedge clk);
        while (!rx_if.ready);
        sent_count++;
    endtask

    task automatic push_eoi();
        push_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        rx_if.valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_delimiter(input logic [7:0] d);
        wait_idle();
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = d;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 8'($urandom_range(0, 255));
        sb.delimiter = d;
    endtask

    function automatic logic [7:0] field_char();
        if ($urandom_range(0, 4) != 0)
            return 8'($urandom_range(8'h20, 8'h7E));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] quoted_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 8'($urandom_range(8'h20, 8'h7E));
        if (r == 6)
            return sb.delimiter;
        if (r == 7)
            return ($urandom_range(0, 1) != 0) ? CR_BYTE : LF_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_record();
        int n_fields;
        int len;
        bit quoted;
        n_fields = $urandom_range(1, 5);
        for (int f = 0; f < n_fields; f++)
        begin
            if (f != 0)
                push_byte(sb.delimiter, 1'b0);
            quoted = ($urandom_range(0, 2) == 0);
            len    = $urandom_range(0, 6);
            if (quoted)
                push_byte(QUOTE_BYTE, 1'b0);
            for (int k = 0; k < len; k++)
            begin
                if (quoted && $urandom_range(0, 5) == 0)
                begin
                    push_byte(QUOTE_BYTE, 1'b0);
                    push_byte(QUOTE_BYTE, 1'b0);
                end
                else
                    push_byte(quoted ? quoted_char() : field_char(), 1'b0);
            end
            if (quoted && $urandom_range(0, 15) != 0)
                push_byte(QUOTE_BYTE, 1'b0);
        end
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                push_byte(CR_BYTE, 1'b0);
                push_byte(LF_BYTE, 1'b0);
            end
            3, 4, 5: push_byte(LF_BYTE, 1'b0);
            6, 7:    push_byte(CR_BYTE, 1'b0);
            8:       push_eoi();
            default: ;
        endcase
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 8);
        repeat (n)
        begin
            case ($urandom_range(0, 11))
                0, 1:    push_byte(QUOTE_BYTE, 1'b0);
                2:       push_byte(sb.delimiter, 1'b0);
                3:       push_byte(CR_BYTE, 1'b0);
                4:       push_byte(LF_BYTE, 1'b0);
                5:       push_eoi();
                default: push_byte(8'($urandom_range(0, 255)), 1'b0);
            endcase
        end
    endtask

    task automatic random_phase(input int n);
        int stop_at;
        stop_at = sent_count + n;
        while (sent_count < stop_at)
        begin
            if ($urandom_range(0, 99) < 85)
                send_record();
            else
                send_noise();
        end
    endtask

    task automatic directed_run();
        logic [7:0] text[$];
        // a,"b,""c"<CR><LF><LF>,<00><FF><LF>"z then end, end, "" then end
        text = '{8'h61, 8'h2C, QUOTE_BYTE, 8'h62, 8'h2C, QUOTE_BYTE, QUOTE_BYTE,
                 8'h63, QUOTE_BYTE, CR_BYTE, LF_BYTE, LF_BYTE, 8'h2C, 8'h00, 8'hFF,
                 LF_BYTE, QUOTE_BYTE, 8'h7A};
        foreach (text[i])
            push_byte(text[i], 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b1);
        push_byte(QUOTE_BYTE, 1'b0);
        push_byte(QUOTE_BYTE, 1'b0);
        push_eoi();
    endtask

    initial
    begin : stimulus
        logic [7:0] delims[$];
        error_count        = 0;
        cycle_count        = 0;
        sent_count         = 0;
        calm               = 1'b0;
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = 8'h00;
        rx_if.valid        = 1'b0;
        rx_if.data_byte    = 8'h00;
        rx_if.end_of_input = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_run();

        delims = '{DELIMITER_INIT, 8'h00, 8'hFF, QUOTE_BYTE, LF_BYTE, CR_BYTE, 8'h09,
                   8'h3B, 8'($urandom_range(0, 255)), DELIMITER_INIT};
        foreach (delims[i])
        begin
            set_delimiter(delims[i]);
            random_phase(PHASE_ITEMS);
        end

        wait_idle();
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
